/* src/fcbe_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the float compact binary encoder.
// Used by fcbe_front, fcbe_queue, fcbe_back and the top level.
package fcbe_pkg;

  // Encoded forms; special values travel as the short form
  typedef enum logic [1:0] {
    FORM_SHORT,
    FORM_MEDIUM,
    FORM_LONG
  } form_t;

  // One classified value waiting to be serialised
  typedef struct packed {
    form_t       form;
    logic [7:0]  e_hi;   // long form exponent, high byte
    logic [7:0]  e_lo;   // long form low byte, or the short/medium exponent byte
    logic [63:0] mant;   // mantissa word, left-aligned
  } entry_t;

  // Queue fill as seen by the front end
  typedef struct packed {
    logic       empty;
    logic [2:0] level;
  } q_status_t;

  // Queue geometry
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = 2;

  // Configuration register indexes
  localparam logic [7:0] CFG_SHORT  = 8'd0;
  localparam logic [7:0] CFG_MEDIUM = 8'd1;
  localparam logic [7:0] CFG_LONG   = 8'd2;

  // Run lengths in bytes
  localparam logic [3:0] LEN_SHORT  = 4'd4;
  localparam logic [3:0] LEN_MEDIUM = 4'd6;
  localparam logic [3:0] LEN_LONG   = 4'd11;

  // Exponent biases and masks
  localparam logic [15:0] LONG_BIAS  = 16'd16383;
  localparam logic [7:0]  SHORT_BIAS = 8'd63;
  localparam logic [63:0] MASK_LOW32 = 64'h0000_0000_ffff_ffff;
  localparam logic [63:0] MASK_LOW48 = 64'h0000_ffff_ffff_ffff;
  localparam logic [15:0] NEG_LONG   = 16'h8000;
  localparam logic [7:0]  NEG_SHORT  = 8'h80;

  // Fixed bytes of the special values
  localparam logic [7:0]  SPEC_EXP_POS = 8'h7F;
  localparam logic [7:0]  SPEC_EXP_NEG = 8'hFF;
  localparam logic [7:0]  ZERO_EXP     = 8'h3F;
  localparam logic [63:0] NAN_MANT     = 64'h0100_0000_0000_0000;

  // Leading-zero count of a nonzero 52-bit fraction
  function automatic logic [5:0] lzc52(input logic [51:0] f);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 52; i++) begin
      if (f[i]) begin
        n = 6'(51 - i);
      end
    end
    return n;
  endfunction

endpackage

/* src/float_compact_binary_encoder.sv */
`timescale 1ns / 1ps
// Top level of the float compact binary encoder: configuration registers,
// front end, queue and back end. Depends on fcbe_pkg and the fcbe_* modules.
//
// Usage:
//   Request channel: drive value_bits (a binary64 bit pattern) with start;
//   the request is taken at a rising edge where start is high and busy low.
//   Result channel: each encoded byte appears on out_byte for one cycle with
//   byte_valid high; last_byte marks the final byte of a value's run. The
//   receiver cannot stall, so bytes leave at one per cycle.
//   Configuration: cfg_index/cfg_data with cfg_valid; cfg_ready is always
//   high. Index 0 is the short code, 1 the medium code, 2 the long code;
//   other indexes are ignored. Write only while the block is idle.
// Path: with the back end idle, the first byte of a run passes from the edge
//   that takes the request through two front-end stages, the queue write,
//   the serialiser load and the output register.
// Rates: runs are 4, 6 or 11 bytes for the short, medium and long
//   forms, sent by the byte serialiser at one byte a cycle. The front
//   end takes one request a cycle until in-flight plus queued requests reach four.
// Reset: synchronous, active high; clears the codes to zero and empties
//   the pipeline and queue.
module float_compact_binary_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] value_bits,
  output logic        byte_valid,
  output logic [7:0]  out_byte,
  output logic        last_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [7:0] short_code;
  logic [7:0] medium_code;
  logic [7:0] long_code;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      short_code  <= 8'd0;
      medium_code <= 8'd0;
      long_code   <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fcbe_pkg::CFG_SHORT:  short_code  <= cfg_data;
        fcbe_pkg::CFG_MEDIUM: medium_code <= cfg_data;
        fcbe_pkg::CFG_LONG:   long_code   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic                push;
  fcbe_pkg::entry_t    push_data;
  logic                pop;
  fcbe_pkg::entry_t    pop_data;
  fcbe_pkg::q_status_t q_stat;

  // Classifier
  fcbe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .value_bits (value_bits),
    .busy       (busy),
    .q_stat     (q_stat),
    .push       (push),
    .push_data  (push_data)
  );

  // Decoupling queue
  fcbe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  // Byte serialiser
  fcbe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .short_code  (short_code),
    .medium_code (medium_code),
    .long_code   (long_code),
    .q_stat      (q_stat),
    .q_data      (pop_data),
    .pop         (pop),
    .byte_valid  (byte_valid),
    .out_byte    (out_byte),
    .last_byte   (last_byte)
  );

endmodule

/* src/fcbe_front.sv */
`timescale 1ns / 1ps
// Front end: takes requests, counts leading zeros, normalises and classifies.
// Depends on fcbe_pkg.
module fcbe_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [63:0]           value_bits,
  output logic                  busy,
  input  fcbe_pkg::q_status_t   q_stat,
  output logic                  push,
  output fcbe_pkg::entry_t      push_data
);

  logic        s1_v;
  logic [63:0] s1_val;
  logic        s2_v;
  logic [63:0] s2_val;
  logic [5:0]  s2_lzc;

  logic [2:0]  pending;
  logic        accept;

  // Hold off new requests when the queue could not absorb everything in flight
  always_comb begin
    pending = {2'b00, s1_v} + {2'b00, s2_v} + q_stat.level;
    busy    = (pending >= 3'(fcbe_pkg::QDEPTH));
    accept  = start && !busy;
  end

  // Stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= accept;
      s2_v <= s1_v;
    end
    if (accept) begin
      s1_val <= value_bits;
    end
    s2_val <= s1_val;
    s2_lzc <= fcbe_pkg::lzc52(s1_val[51:0]);
  end

  // Stage 2: normalise and pick the form
  logic        sign;
  logic [10:0] bexp;
  logic [51:0] frac;
  logic        is_spec;
  logic        is_zero;
  logic        is_sub;
  logic [11:0] ex;
  logic [63:0] mant;
  logic        neg;
  logic        wide_exp;
  logic [15:0] e_long;
  logic [7:0]  e_short;
  logic [6:0]  sub_shift;
  fcbe_pkg::entry_t ent;

  always_comb begin
    sign      = s2_val[63];
    bexp      = s2_val[62:52];
    frac      = s2_val[51:0];
    is_spec   = (bexp == 11'h7FF);
    is_zero   = (bexp == 11'd0) && (frac == 52'd0);
    is_sub    = (bexp == 11'd0) && !is_zero;
    sub_shift = {1'b0, s2_lzc} + 7'd13;

    if (is_sub) begin
      ex   = 12'd0 - 12'd1022 - {6'd0, s2_lzc};
      mant = {12'd0, frac} << sub_shift;
    end else if (is_zero) begin
      ex   = 12'd0;
      mant = 64'd0;
    end else begin
      ex   = {1'b0, bexp} - 12'd1022;
      mant = {frac, 12'd0};
    end
    neg      = sign && !is_zero;
    wide_exp = ($signed(ex) > 12'sd63) || ($signed(ex) < -12'sd63);
    e_long   = {{4{ex[11]}}, ex} + fcbe_pkg::LONG_BIAS;
    e_short  = ex[7:0] + fcbe_pkg::SHORT_BIAS;
    if (neg) begin
      e_long  = e_long | fcbe_pkg::NEG_LONG;
      e_short = e_short | fcbe_pkg::NEG_SHORT;
    end

    ent.mant = mant;
    ent.e_hi = e_long[15:8];
    ent.e_lo = e_short;
    if (is_spec) begin
      ent.form = fcbe_pkg::FORM_SHORT;
      ent.e_hi = 8'd0;
      if (frac != 52'd0) begin
        ent.e_lo = fcbe_pkg::SPEC_EXP_POS;
        ent.mant = fcbe_pkg::NAN_MANT;
      end else begin
        ent.e_lo = sign ? fcbe_pkg::SPEC_EXP_NEG : fcbe_pkg::SPEC_EXP_POS;
        ent.mant = 64'd0;
      end
    end else if (is_zero) begin
      ent.form = fcbe_pkg::FORM_SHORT;
      ent.e_lo = fcbe_pkg::ZERO_EXP;
    end else if (((mant & fcbe_pkg::MASK_LOW32) != 64'd0) || wide_exp) begin
      ent.form = fcbe_pkg::FORM_LONG;
      ent.e_lo = e_long[7:0];
    end else if ((mant & fcbe_pkg::MASK_LOW48) != 64'd0) begin
      ent.form = fcbe_pkg::FORM_MEDIUM;
    end else begin
      ent.form = fcbe_pkg::FORM_SHORT;
    end
  end

  assign push      = s2_v;
  assign push_data = ent;

endmodule

/* src/fcbe_queue.sv */
`timescale 1ns / 1ps
// Short queue between the front and back ends.
// Depends on fcbe_pkg.
module fcbe_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  fcbe_pkg::entry_t    push_data,
  input  logic                pop,
  output fcbe_pkg::entry_t    pop_data,
  output fcbe_pkg::q_status_t stat
);

  fcbe_pkg::entry_t            mem [fcbe_pkg::QDEPTH];
  logic [fcbe_pkg::QAW-1:0]    wr_ptr;
  logic [fcbe_pkg::QAW-1:0]    rd_ptr;
  logic [fcbe_pkg::QAW:0]      count;

  // Storage; the front end never pushes into a full queue
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + {2'b00, push} - {2'b00, pop};
    end
  end

  assign pop_data   = mem[rd_ptr];
  assign stat.empty = (count == '0);
  assign stat.level = count;

endmodule

/* src/fcbe_back.sv */
`timescale 1ns / 1ps
// Back end: serialises one queued entry into its byte run, one byte a cycle.
// Depends on fcbe_pkg.
module fcbe_back (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          short_code,
  input  logic [7:0]          medium_code,
  input  logic [7:0]          long_code,
  input  fcbe_pkg::q_status_t q_stat,
  input  fcbe_pkg::entry_t    q_data,
  output logic                pop,
  output logic                byte_valid,
  output logic [7:0]          out_byte,
  output logic                last_byte
);

  logic             active;
  fcbe_pkg::entry_t cur;
  logic [3:0]       idx;

  logic [3:0] len;
  logic [7:0] code;
  logic [3:0] mpos;
  logic [2:0] k;
  logic [7:0] byte_sel;
  logic       last_now;

  // Byte selection for the current position
  always_comb begin
    case (cur.form)
      fcbe_pkg::FORM_LONG: begin
        len  = fcbe_pkg::LEN_LONG;
        code = long_code;
        mpos = idx - 4'd3;
      end
      fcbe_pkg::FORM_MEDIUM: begin
        len  = fcbe_pkg::LEN_MEDIUM;
        code = medium_code;
        mpos = idx - 4'd2;
      end
      default: begin
        len  = fcbe_pkg::LEN_SHORT;
        code = short_code;
        mpos = idx - 4'd2;
      end
    endcase
    k = mpos[2:0];

    if (idx == 4'd0) begin
      byte_sel = code;
    end else if (cur.form == fcbe_pkg::FORM_LONG && idx == 4'd1) begin
      byte_sel = cur.e_hi;
    end else if ((cur.form == fcbe_pkg::FORM_LONG && idx == 4'd2) ||
                 (cur.form != fcbe_pkg::FORM_LONG && idx == 4'd1)) begin
      byte_sel = cur.e_lo;
    end else begin
      byte_sel = 8'((cur.mant << {k, 3'b000}) >> 56);
    end

    last_now = active && (idx == len - 4'd1);
    pop      = (!active || last_now) && !q_stat.empty;
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      byte_valid <= 1'b0;
    end else begin
      byte_valid <= active;
      if (pop) begin
        active <= 1'b1;
      end else if (last_now) begin
        active <= 1'b0;
      end
    end
    out_byte  <= byte_sel;
    last_byte <= last_now;
    if (pop) begin
      cur <= q_data;
      idx <= 4'd0;
    end else if (active) begin
      idx <= idx + 4'd1;
    end
  end

endmodule

/* sim/fcbe_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the float compact binary encoder: watches the request,
// configuration and byte channels, predicts each byte run and compares.
// Depends on fcbe_pkg for the form type, register indexes and constants.
module fcbe_checker
  import fcbe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [63:0] value_bits,
  input  logic        byte_valid,
  input  logic [7:0]  out_byte,
  input  logic        last_byte,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          failures,
  output int          pending
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } run_byte_t;

  // Bytes still owed by the block, oldest request first
  run_byte_t  expected_run[$];
  run_byte_t  head;
  logic [7:0] code_short  = '0;
  logic [7:0] code_medium = '0;
  logic [7:0] code_long   = '0;
  int         fail_count  = 0;

  task automatic queue_byte(input logic [7:0] data, input logic last);
    run_byte_t b;
    b.data = data;
    b.last = last;
    expected_run.push_back(b);
  endtask

  // Predict the byte run for one binary64 pattern
  task automatic encode_value(input logic [63:0] v);
    logic [10:0] bexp;
    logic [51:0] frac;
    logic        neg;
    int          ex;
    int          p;
    int          nbytes;
    logic [63:0] mant;
    logic [15:0] e16;
    logic [7:0]  e8;
    form_t       form;
    bexp = v[62:52];
    frac = v[51:0];
    if (bexp == '1) begin
      // NaN and the infinities: fixed short run
      queue_byte(code_short, 1'b0);
      if (frac != '0) begin
        queue_byte(SPEC_EXP_POS, 1'b0);
        queue_byte(NAN_MANT[63:56], 1'b0);
      end else begin
        queue_byte(v[63] ? SPEC_EXP_NEG : SPEC_EXP_POS, 1'b0);
        queue_byte(8'h00, 1'b0);
      end
      queue_byte(8'h00, 1'b1);
    end else begin
      if (bexp == '0 && frac == '0) begin
        // zero of either sign never carries the sign
        ex = 0;
        mant = '0;
        neg = 1'b0;
      end else if (bexp == '0) begin
        // subnormal: normalise on the leading one
        p = 51;
        while (p > 0 && !frac[p]) p--;
        ex = p - 1073;
        mant = {12'd0, frac} << (64 - p);
        neg = v[63];
      end else begin
        ex = int'(bexp) - 1022;
        mant = {frac, 12'd0};
        neg = v[63];
      end

      if ((mant & MASK_LOW32) != '0 || ex > 63 || ex < -63) form = FORM_LONG;
      else if ((mant & MASK_LOW48) != '0) form = FORM_MEDIUM;
      else form = FORM_SHORT;

      e16 = 16'(ex + int'(LONG_BIAS));
      e8  = 8'(ex + int'(SHORT_BIAS));
      if (neg) begin
        e16 = e16 | NEG_LONG;
        e8  = e8 | NEG_SHORT;
      end

      case (form)
        FORM_LONG: begin
          queue_byte(code_long, 1'b0);
          queue_byte(e16[15:8], 1'b0);
          queue_byte(e16[7:0], 1'b0);
          nbytes = 8;
        end
        FORM_MEDIUM: begin
          queue_byte(code_medium, 1'b0);
          queue_byte(e8, 1'b0);
          nbytes = 4;
        end
        default: begin
          queue_byte(code_short, 1'b0);
          queue_byte(e8, 1'b0);
          nbytes = 2;
        end
      endcase
      // mantissa, high byte first
      for (int i = 0; i < nbytes; i++) begin
        queue_byte(mant[63 - 8 * i -: 8], i == nbytes - 1);
      end
    end
  endtask

  // Compare bytes first, then take new requests and register writes
  always @(posedge clk) begin
    if (rst) begin
      code_short  = '0;
      code_medium = '0;
      code_long   = '0;
      expected_run.delete();
    end else begin
      if (byte_valid) begin
        if (expected_run.size() == 0) begin
          if (fail_count < 10) begin
            $display("%0t: unexpected byte %02h last %0b", $time, out_byte, last_byte);
          end
          fail_count++;
        end else begin
          head = expected_run.pop_front();
          if (head.data !== out_byte || head.last !== last_byte) begin
            if (fail_count < 10) begin
              $display("%0t: byte mismatch: expected %02h last %0b, got %02h last %0b",
                       $time, head.data, head.last, out_byte, last_byte);
            end
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        encode_value(value_bits);
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SHORT:  code_short  = cfg_data;
          CFG_MEDIUM: code_medium = cfg_data;
          CFG_LONG:   code_long   = cfg_data;
          default: ;
        endcase
      end
    end
    failures <= fail_count;
    pending  <= expected_run.size();
  end

endmodule

/* sim/float_compact_binary_encoder_test.sv */
`timescale 1ns / 1ps
// Top of the encoder testbench: clock, reset, request and register stimulus.
// Depends on fcbe_pkg, float_compact_binary_encoder and fcbe_checker.
module float_compact_binary_encoder_test;
  import fcbe_pkg::*;

  localparam int CYCLE_LIMIT = 100000;

  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        start      = 1'b0;
  logic [63:0] value_bits = '0;
  logic        cfg_valid  = 1'b0;
  logic [7:0]  cfg_index  = '0;
  logic [7:0]  cfg_data   = '0;
  logic        busy;
  logic        byte_valid;
  logic [7:0]  out_byte;
  logic        last_byte;
  logic        cfg_ready;
  int          failures;
  int          pending;
  int          cycles  = 0;
  bit          gaps_on = 1'b1;

  // Corner values: zeros, infinities, NaNs, subnormals, exponent edges, each form
  logic [63:0] corner_values[$] = {
    64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
    64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
    64'h7FF8_0000_0000_0000, 64'h7FF0_0000_0000_0001,
    64'hFFFF_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0000,
    64'hBFF0_0000_0000_0000, 64'h3FF8_0000_0000_0000,
    64'h0000_0000_0000_0001, 64'h000F_FFFF_FFFF_FFFF,
    64'h8008_0000_0000_0000, 64'h0010_0000_0000_0000,
    64'h7FEF_FFFF_FFFF_FFFF, 64'hFFEF_FFFF_FFFF_FFFF,
    64'h43D0_0000_0000_0000, 64'h43E0_0000_0000_0000,
    64'h3BF0_0000_0000_0000, 64'hBBE0_0000_0000_0000,
    64'h3FF0_0000_0010_0000, 64'hBFFF_FFFF_FFF0_0000,
    64'h3FF0_0000_0000_0001
  };

  initial begin
    forever #1 clk = ~clk;
  end

  float_compact_binary_encoder u_dut (.*);

  fcbe_checker u_checker (.*);

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Present one request and hold it until taken; start stays high afterwards unless a random gap follows
  task automatic issue(input logic [63:0] v);
    start      <= 1'b1;
    value_bits <= v;
    do @(posedge clk); while (busy);
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Set all three type bytes, then poke an index outside the register list
  task automatic write_codes(input logic [7:0] s, input logic [7:0] m, input logic [7:0] l);
    write_reg(CFG_SHORT, s);
    write_reg(CFG_MEDIUM, m);
    write_reg(CFG_LONG, l);
    write_reg(8'($urandom_range(int'(CFG_LONG) + 1, 255)), 8'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Let every outstanding byte come out, then idle with start low
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Mostly well-shaped values aimed at each form and exponent edge, some raw noise
  function automatic logic [63:0] rand_value();
    logic [63:0] noise;
    logic [10:0] bexp;
    logic [51:0] frac;
    noise = {$urandom, $urandom};
    if ($urandom_range(0, 4) == 0) return noise;
    case ($urandom_range(0, 7))
      0:       bexp = '0;
      1:       bexp = '1;
      2, 3, 4: bexp = 11'($urandom_range(959, 1085));
      5:       bexp = 11'($urandom_range(955, 963));
      6:       bexp = 11'($urandom_range(1081, 1089));
      default: bexp = noise[62:52];
    endcase
    case ($urandom_range(0, 4))
      0:       frac = {noise[51:36], 36'd0};
      1:       frac = {noise[51:20], 20'd0};
      2:       frac = noise[51:0];
      3:       frac = 52'd1 << $urandom_range(0, 51);
      default: frac = '0;
    endcase
    return {noise[63], bexp, frac};
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // corners with the type bytes at their reset value
    foreach (corner_values[i]) issue(corner_values[i]);
    drain();

    write_codes(8'hFF, 8'hFF, 8'hFF);
    repeat (42) issue(rand_value());
    drain();

    write_codes(8'h00, 8'h80, 8'h7F);
    repeat (42) issue(rand_value());
    drain();

    // back-to-back requests for the last stretch
    write_codes(8'($urandom), 8'($urandom), 8'($urandom));
    gaps_on = 1'b0;
    repeat (42) issue(rand_value());
    drain();

    if (failures == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/fcbe_pkg.sv
src/fcbe_front.sv
src/fcbe_queue.sv
src/fcbe_back.sv
src/float_compact_binary_encoder.sv
sim/fcbe_checker.sv
sim/float_compact_binary_encoder_test.sv
